>>> rtl/mtf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtf_pkg
// Shared types, codes and sizes for the move-to-front list unit.
// ----------------------------------------------------------------------------
package mtf_pkg;

  localparam int DEPTH   = 16;
  localparam int COUNT_W = $clog2(DEPTH + 1);
  localparam int INDEX_W = 4;
  localparam int CMP_W   = (COUNT_W > INDEX_W) ? COUNT_W : INDEX_W;
  localparam int WORD_W  = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_FETCH  = 2'd1,
    CMD_POP    = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_BAD_INDEX = 2'd2,
    STAT_FULL      = 2'd3
  } stat_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_BUSY = 1'b1
  } state_t;

  typedef struct packed {
    logic [1:0]                command;
    logic signed [WORD_W-1:0]  item_value;
    logic [INDEX_W-1:0]        item_index;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]  result_value;
    logic [1:0]                status;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctl_t;

endpackage
`default_nettype wire

>>> rtl/move_to_front_list_unit.sv
`default_nettype none
// Move-to-front list unit.
// A request is captured into the request register, then run into the result
// register; a new request is taken only after the last one has run, and the
// list update runs through the per-position shift muxes when the request runs.
// A stalled result holds off the run of the next request until it drains.
// Reset (synchronous, active high) empties the list; stored words stay unset.
// ----------------------------------------------------------------------------
// move_to_front_list_unit
// Bounded list with insert-at-front, fetch-and-move-to-front and pop-front.
// ----------------------------------------------------------------------------
module move_to_front_list_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire mtf_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output mtf_pkg::rsp_t      rsp
);
  import mtf_pkg::*;

  ctl_t ctl;

  mtf_control u_control (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .ctl       (ctl)
  );

  mtf_datapath u_datapath (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .req (req),
    .rsp (rsp)
  );

endmodule
`default_nettype wire

>>> rtl/mtf_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtf_datapath
// Request register, list storage with per-position shift muxes, entry count
// and result register.
// ----------------------------------------------------------------------------
module mtf_datapath (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire mtf_pkg::ctl_t ctl,
  input  wire mtf_pkg::req_t req,
  output mtf_pkg::rsp_t      rsp
);
  import mtf_pkg::*;

  req_t                req_q;
  logic [WORD_W-1:0]   entries [DEPTH];
  logic [WORD_W-1:0]   entries_next [DEPTH];
  logic [COUNT_W-1:0]  count;
  logic [COUNT_W-1:0]  count_next;
  rsp_t                rsp_q;
  rsp_t                rsp_next;

  always_comb begin
    logic [WORD_W-1:0] got;
    logic [CMP_W-1:0]  idx;
    logic              empty;
    logic              full;
    logic              bad_idx;
    got     = '0;
    idx     = CMP_W'(req_q.item_index);
    empty   = (count == '0);
    full    = (count == COUNT_W'(DEPTH));
    bad_idx = (idx >= CMP_W'(count));
    for (int p = 0; p < DEPTH; p++) begin
      entries_next[p] = entries[p];
      if (idx == CMP_W'(p)) begin
        got = entries[p];
      end
    end
    count_next = count;
    rsp_next   = '{result_value: '0, status: STAT_OK};
    unique case (cmd_t'(req_q.command))
      CMD_INSERT: begin
        if (full) begin
          rsp_next.status = STAT_FULL;
        end else begin
          entries_next[0] = req_q.item_value;
          for (int p = 1; p < DEPTH; p++) begin
            entries_next[p] = entries[p-1];
          end
          count_next = count + 1'b1;
        end
      end
      CMD_FETCH: begin
        if (empty) begin
          rsp_next.status = STAT_EMPTY;
        end else if (bad_idx) begin
          rsp_next.status = STAT_BAD_INDEX;
        end else begin
          entries_next[0] = got;
          for (int p = 1; p < DEPTH; p++) begin
            if (CMP_W'(p) <= idx) begin
              entries_next[p] = entries[p-1];
            end
          end
          rsp_next.result_value = got;
        end
      end
      CMD_POP: begin
        if (empty) begin
          rsp_next.status = STAT_EMPTY;
        end else begin
          rsp_next.result_value = entries[0];
          for (int p = 0; p < DEPTH - 1; p++) begin
            entries_next[p] = entries[p+1];
          end
          count_next = count - 1'b1;
        end
      end
      CMD_NONE: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.exec) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_q <= req;
    end
    if (ctl.exec) begin
      entries <= entries_next;
      rsp_q   <= rsp_next;
    end
  end

  assign rsp = rsp_q;

endmodule
`default_nettype wire

>>> rtl/mtf_control.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtf_control
// Request sequencer: capture a request, run it once the result register is
// free, and track the result valid flag.
// ----------------------------------------------------------------------------
module mtf_control (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_stall,
  output logic          rsp_valid,
  input  wire logic     rsp_stall,
  output mtf_pkg::ctl_t ctl
);
  import mtf_pkg::*;

  state_t state;
  state_t state_next;
  logic   rsp_valid_next;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (ctl.exec) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    ctl.load       = 1'b0;
    ctl.exec       = 1'b0;
    req_stall      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        ctl.load = req_valid;
      end
      ST_BUSY: begin
        req_stall = 1'b1;
        // run only when the result register is empty or being drained
        ctl.exec  = !rsp_valid || !rsp_stall;
      end
    endcase
    rsp_valid_next = ctl.exec || (rsp_valid && rsp_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule
`default_nettype wire

>>> bench/mtf_list_checker.sv
// ----------------------------------------------------------------------------
// mtf_list_checker
// Watches both channels of the move-to-front list unit. It keeps its own copy
// of the list, works out the result of each request taken, and compares the
// results that come back in order, field by field.
// ----------------------------------------------------------------------------
module mtf_list_checker
  import mtf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   fail_count,
  output int   pending
);

  logic signed [WORD_W-1:0] list_words [DEPTH];
  int                       list_len;
  rsp_t                     expected_rsp [$];

  // Apply one request to the shadow list and return the result it gives.
  function automatic rsp_t apply_command(req_t r);
    rsp_t                     o;
    logic signed [WORD_W-1:0] picked;
    o.result_value = '0;
    o.status       = STAT_OK;
    case (cmd_t'(r.command))
      CMD_INSERT: begin
        if (list_len >= DEPTH) begin
          o.status = STAT_FULL;
        end else begin
          for (int i = list_len; i > 0; i--) list_words[i] = list_words[i-1];
          list_words[0] = r.item_value;
          list_len++;
        end
      end
      CMD_FETCH: begin
        if (list_len == 0) begin
          o.status = STAT_EMPTY;
        end else if (int'(r.item_index) >= list_len) begin
          o.status = STAT_BAD_INDEX;
        end else begin
          picked = list_words[r.item_index];
          for (int i = int'(r.item_index); i > 0; i--) list_words[i] = list_words[i-1];
          list_words[0]  = picked;
          o.result_value = picked;
        end
      end
      CMD_POP: begin
        if (list_len == 0) begin
          o.status = STAT_EMPTY;
        end else begin
          o.result_value = list_words[0];
          for (int i = 0; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    int   errs;
    errs = 0;
    if (rst) begin
      expected_rsp.delete();
      list_len = 0;
    end else begin
      // compare first so a request taken at this edge cannot match early
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp.size() == 0) begin
          $error("result with nothing expected: result_value %0d, status %0d",
                 rsp.result_value, rsp.status);
          errs++;
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.result_value !== want.result_value) begin
            $error("result_value: expected %0d, actual %0d",
                   want.result_value, rsp.result_value);
            errs++;
          end
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp.status);
            errs++;
          end
        end
      end
      if (req_valid && !req_stall) expected_rsp.push_back(apply_command(req));
    end
    pending <= expected_rsp.size();
    if (errs != 0) fail_count <= fail_count + errs;
  end

endmodule

>>> bench/move_to_front_list_unit_test.sv
// ----------------------------------------------------------------------------
// move_to_front_list_unit_test
// Drives the list unit with a directed opening (empty, full, bad index, front
// fetch, unused command, extreme words) and then fill and drain waves of
// random requests under several idle and stall mixes; a checker beside the
// unit predicts and compares every result.
// ----------------------------------------------------------------------------
module move_to_front_list_unit_test;
  import mtf_pkg::*;

  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic rsp_stall = 1'b0;
  req_t req       = '0;
  logic req_stall;
  logic rsp_valid;
  rsp_t rsp;
  int   fail_count;
  int   pending;

  int   idle_pct   = 0;
  int   stall_pct  = 0;
  int   list_fill  = 0;
  bit   filling    = 1'b1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  move_to_front_list_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  mtf_list_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    #2_000_000;
    $display("** move_to_front_list_unit: FAILED **");
    $finish;
  end

  function automatic req_t make_req(cmd_t c, logic signed [WORD_W-1:0] v,
                                    logic [INDEX_W-1:0] ix);
    req_t r;
    r.command    = c;
    r.item_value = v;
    r.item_index = ix;
    return r;
  endfunction

  // Fill and drain in waves so the list spends time both full and empty.
  function automatic req_t pick_request();
    req_t r;
    int   roll;
    roll = $urandom_range(99);
    r.item_index = INDEX_W'($urandom);
    case ($urandom_range(15))
      0:       r.item_value = WORD_MIN;
      1:       r.item_value = WORD_MAX;
      2:       r.item_value = '0;
      3:       r.item_value = -1;
      default: r.item_value = $urandom;
    endcase
    if (roll < 2)                          r.command = CMD_NONE;
    else if (roll < (filling ? 62 : 12))   r.command = CMD_INSERT;
    else if (roll < (filling ? 90 : 45))   r.command = CMD_FETCH;
    else                                   r.command = CMD_POP;
    if (r.command == CMD_FETCH && list_fill > 0 && $urandom_range(9) < 8)
      r.item_index = INDEX_W'($urandom_range(list_fill - 1));
    return r;
  endfunction

  // Hold the request until taken; track occupancy to steer the waves.
  task automatic send_request(req_t r);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    case (cmd_t'(r.command))
      CMD_INSERT: if (list_fill < DEPTH) list_fill++;
      CMD_POP:    if (list_fill > 0) list_fill--;
      default: ;
    endcase
    if (list_fill == DEPTH)          filling = 1'b0;
    else if (list_fill == 0)         filling = 1'b1;
    else if ($urandom_range(99) == 0) filling = !filling;
  endtask

  task automatic drain_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int   sent;
    req_t r;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(make_req(CMD_POP, WORD_MAX, '0));
    send_request(make_req(CMD_FETCH, WORD_MIN, 4'hf));
    send_request(make_req(CMD_INSERT, WORD_MIN, 4'hf));
    send_request(make_req(CMD_INSERT, WORD_MAX, '0));
    send_request(make_req(CMD_INSERT, '0, 4'h5));
    send_request(make_req(CMD_INSERT, -1, 4'ha));
    send_request(make_req(CMD_FETCH, '0, 4'h0));
    send_request(make_req(CMD_FETCH, -1, 4'h3));
    send_request(make_req(CMD_FETCH, '0, 4'h4));
    send_request(make_req(CMD_NONE, -1, 4'hf));
    send_request(make_req(CMD_POP, '0, 4'h7));
    repeat (13) send_request(make_req(CMD_INSERT, $urandom, INDEX_W'($urandom)));
    send_request(make_req(CMD_INSERT, WORD_MAX, 4'h0));
    send_request(make_req(CMD_FETCH, $urandom, 4'hf));
    drain_results();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 67; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 67; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      sent = 0;
      while (sent < 175) begin
        r = pick_request();
        send_request(r);
        if (r.command != CMD_NONE) sent++;
      end
      // hold off until every result of this phase is back
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** move_to_front_list_unit: PASSED **");
    end else begin
      $display("** move_to_front_list_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/mtf_pkg.sv
rtl/mtf_datapath.sv
rtl/mtf_control.sv
rtl/move_to_front_list_unit.sv
bench/mtf_list_checker.sv
bench/move_to_front_list_unit_test.sv
